FILE: rtl/cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_pkg
// Shared constants and types for the counted multiset with rank select:
// the action codes, the item structs of both channels and the count
// memory request.
// ----------------------------------------------------------------------------
package cms_pkg;

    // Multiset shape
    localparam int NUM_KINDS = 54;
    localparam int COUNT_MAX = 127;

    // Field widths
    localparam int ACTION_W = 2;
    localparam int KIND_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int TOTAL_W  = 13;

    // Derived limits
    localparam logic [KIND_W-1:0]  KIND_LAST = KIND_W'(NUM_KINDS - 1);
    localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(COUNT_MAX);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(NUM_KINDS * COUNT_MAX);

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_SELECT = 2'd3
    } action_t;

    // Command item
    typedef struct packed {
        action_t             action;
        logic [KIND_W-1:0]   item_kind;
        logic [TOTAL_W-1:0]  rank_k;
    } cmd_t;

    // Response item
    typedef struct packed {
        logic [KIND_W-1:0]   found_kind;
        logic [COUNT_W-1:0]  kind_count;
        logic [TOTAL_W-1:0]  total_count;
        logic                error;
    } rsp_t;

    // Count memory access from the controller
    typedef struct packed {
        logic                rd_en;
        logic [KIND_W-1:0]   rd_addr;
        logic                wr_en;
        logic [KIND_W-1:0]   wr_addr;
        logic [COUNT_W-1:0]  wr_data;
    } ram_req_t;

endpackage

FILE: rtl/cms_count_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_count_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cms_count_ram #(
    parameter int DEPTH = 54,
    parameter int WIDTH = 7,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/cms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cms_ctrl
// Sequencer for the count memory: read-modify-write for insert, delete and
// query, and a one-kind-per-cycle walk for select. Holds the running total
// and the per-entry valid bits that make unwritten counts read as zero.
// ----------------------------------------------------------------------------
module cms_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  cms_pkg::cmd_t                cmd,
    output logic                         res_valid,
    input  logic                         res_ready,
    output cms_pkg::rsp_t                res,
    output cms_pkg::ram_req_t            ram_req,
    input  logic [cms_pkg::COUNT_W-1:0]  ram_rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                              state_reg,   state_next;
    cms_pkg::cmd_t                       cmd_reg,     cmd_next;
    logic [cms_pkg::KIND_W-1:0]          idx_reg,     idx_next;
    logic [cms_pkg::TOTAL_W-1:0]         left_reg,    left_next;
    logic [cms_pkg::TOTAL_W-1:0]         total_reg,   total_next;
    logic [cms_pkg::NUM_KINDS-1:0]       valid_reg,   valid_next;
    logic                                rd_vld_reg,  rd_vld_next;
    cms_pkg::rsp_t                       res_reg,     res_next;

    logic                                accept;
    logic                                kind_ok;
    logic [cms_pkg::COUNT_W-1:0]         cur_count;

    // Count of the entry read last cycle; never-written entries read as zero
    assign cur_count = rd_vld_reg ? ram_rd_data : '0;

    assign accept  = cmd_valid && (state_reg == ST_IDLE);
    assign kind_ok = ({1'b0, cmd.item_kind} < (cms_pkg::KIND_W + 1)'(cms_pkg::NUM_KINDS));

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Next-state and memory request
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        valid_next  = valid_reg;
        res_next    = res_reg;
        ram_req     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    res_next.total_count = total_reg;
                    if (cmd.action == cms_pkg::ACT_SELECT)
                    begin
                        if (cmd.rank_k < total_reg)
                        begin
                            // Start the walk at kind zero
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = '0;
                            idx_next        = '0;
                            left_next       = cmd.rank_k;
                            state_next      = ST_WALK;
                        end
                        else
                        begin
                            res_next.error = 1'b1;
                            state_next     = ST_DONE;
                        end
                    end
                    else if (kind_ok)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = cmd.item_kind;
                        state_next      = ST_EVAL;
                    end
                    else
                    begin
                        res_next.error = 1'b1;
                        state_next     = ST_DONE;
                    end
                end
            end

            ST_EVAL:
            begin
                res_next.kind_count = cur_count;
                state_next          = ST_DONE;
                case (cmd_reg.action)
                    cms_pkg::ACT_INSERT:
                    begin
                        if (cur_count == cms_pkg::COUNT_TOP)
                        begin
                            res_next.error = 1'b1;
                        end
                        else
                        begin
                            ram_req.wr_en        = 1'b1;
                            ram_req.wr_addr      = cmd_reg.item_kind;
                            ram_req.wr_data      = cur_count + 1'b1;
                            valid_next[cmd_reg.item_kind] = 1'b1;
                            total_next           = total_reg + 1'b1;
                            res_next.kind_count  = cur_count + 1'b1;
                            res_next.total_count = total_reg + 1'b1;
                        end
                    end
                    cms_pkg::ACT_DELETE:
                    begin
                        if (cur_count == '0)
                        begin
                            res_next.error = 1'b1;
                        end
                        else
                        begin
                            ram_req.wr_en        = 1'b1;
                            ram_req.wr_addr      = cmd_reg.item_kind;
                            ram_req.wr_data      = cur_count - 1'b1;
                            valid_next[cmd_reg.item_kind] = 1'b1;
                            total_next           = total_reg - 1'b1;
                            res_next.kind_count  = cur_count - 1'b1;
                            res_next.total_count = total_reg - 1'b1;
                        end
                    end
                    cms_pkg::ACT_QUERY:
                    begin
                        res_next.kind_count = cur_count;
                    end
                    default:
                    begin
                        res_next.kind_count = '0;
                        res_next.error      = 1'b1;
                    end
                endcase
            end

            ST_WALK:
            begin
                if (left_reg < cms_pkg::TOTAL_W'(cur_count))
                begin
                    // Rank falls inside this kind
                    res_next.found_kind = idx_reg;
                    res_next.kind_count = cur_count;
                    state_next          = ST_DONE;
                end
                else if (idx_reg == cms_pkg::KIND_LAST)
                begin
                    // Counts ran out: total and counts disagree
                    res_next.error = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    // Advance: fetch the next kind while this one is consumed
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg + 1'b1;
                    idx_next        = idx_reg + 1'b1;
                    left_next       = left_reg - cms_pkg::TOTAL_W'(cur_count);
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Track whether the entry being read was ever written
        rd_vld_next = ram_req.rd_en ? valid_reg[ram_req.rd_addr] : rd_vld_reg;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cmd_reg    <= '0;
            idx_reg    <= '0;
            left_reg   <= '0;
            total_reg  <= '0;
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            idx_reg    <= idx_next;
            left_reg   <= left_next;
            total_reg  <= total_next;
            valid_reg  <= valid_next;
            rd_vld_reg <= rd_vld_next;
            res_reg    <= res_next;
        end
    end

    // Running total stays within what the counts can hold
    assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= cms_pkg::TOTAL_MAX)
        else $error("running total beyond the largest possible sum");

    // The walk never indexes past the last kind
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (idx_reg <= cms_pkg::KIND_LAST))
        else $error("select walk past the last kind");

    // A write never shares a cycle with a read of the count memory
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |-> !ram_req.rd_en)
        else $error("count memory read and write in the same cycle");

    // The total moves by at most one per item, and only on a write
    assert property (@(posedge clk) disable iff (!rst_n)
        !ram_req.wr_en |=> $stable(total_reg))
        else $error("running total changed without a count write");

    // A refused item reports no found kind
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.error) |-> (res.found_kind == '0))
        else $error("refused item carries a found kind");

endmodule

FILE: rtl/counted_multiset_with_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counted_multiset_with_select
// Multiset of item counts per kind with insert, delete, query and
// select-by-rank, built around a single count memory.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Insert, delete and query read the
// kind's count from the memory, update it and then present the response;
// one whose kind is past the last kind is refused without a memory read.
// Select walks the count memory one kind per cycle from kind zero and
// stops at the kind in which the rank falls; a select whose rank is not
// below the running total is refused without a walk. A finished response
// sits in the output register and the next item is taken while it waits
// there. Counts read as zero after reset through per-entry valid bits, so
// the block is ready at once with no clearing pass. A refused item changes
// nothing.
// ----------------------------------------------------------------------------
module counted_multiset_with_select (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  cms_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cms_pkg::rsp_t  rsp
);

    cms_pkg::ram_req_t             ram_req;
    logic [cms_pkg::COUNT_W-1:0]   ram_rd_data;
    logic                          res_valid;
    logic                          res_ready;
    cms_pkg::rsp_t                 res;

    logic                          rsp_valid_reg, rsp_valid_next;
    cms_pkg::rsp_t                 rsp_reg,       rsp_next;

    // Count memory
    cms_count_ram #(
        .DEPTH (cms_pkg::NUM_KINDS),
        .WIDTH (cms_pkg::COUNT_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data)
    );

    // Sequencer
    cms_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data)
    );

    // Output register: load when empty or being drained
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
